// ===== hw/rtl/cpm_pkg.sv =====
// Package for the complex power, magnitude and phasor unit.
// Widths, stage counts, the mode code and the sideband struct.
// No dependencies.
package cpm_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	localparam int MAG_W        = SAMPLE_WIDTH + 1;      // |sample|, holds 2^FRAC_BITS
	localparam int SQ_W         = 2 * FRAC_BITS + 1;     // one square, at most 2^30
	localparam int POW_W        = 2 * FRAC_BITS + 2;     // sum of squares, at most 2^31
	localparam int QUO_W        = 2 * FRAC_BITS + 1;     // a^2 * 2^30 / power, at most 2^30
	localparam int DIV_STAGES   = 2 * FRAC_BITS + 1;
	localparam int ROOT_W       = POW_W / 2;
	localparam int REM_W        = ROOT_W + 2;
	localparam int ROOT_STAGES  = ROOT_W;
	localparam int LANES        = 3;
	localparam int LANE_LEVEL   = 0;
	localparam int LANE_RE      = 1;
	localparam int LANE_IM      = 2;
	localparam int FRONT_STAGES = 3;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + ROOT_STAGES + 1;
	localparam int TAG_W        = 8;
	localparam int LEVEL_W      = 32;

	typedef enum logic {
		MODE_POWER     = 1'b0,
		MODE_MAGNITUDE = 1'b1
	} mode_t;

	// fields that ride alongside the arithmetic
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             re_neg;
		logic             im_neg;
		logic [POW_W-1:0] power;
	} side_t;

endpackage

// ===== hw/rtl/cpm_front.sv =====
// Front stages: absolute values, squares, power sum.
// Depends on cpm_pkg.
module cpm_front import cpm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [TAG_W-1:0]        in_tag,
	input  logic signed [SAMPLE_WIDTH-1:0] in_re,
	input  logic signed [SAMPLE_WIDTH-1:0] in_im,
	input  logic                    in_last,
	output logic                    out_valid,
	output side_t                   out_side,
	output logic [SQ_W-1:0]         out_num_re,
	output logic [SQ_W-1:0]         out_num_im
);

	logic [MAG_W-1:0] ext_re, ext_im, abs_re, abs_im;
	logic [MAG_W-1:0] a_s1, b_s1;
	logic             valid_s1, valid_s2, valid_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2;
	logic             last_s1, last_s2, rneg_s1, rneg_s2, ineg_s1, ineg_s2;
	logic [2*MAG_W-1:0] asq_full, bsq_full;
	logic [SQ_W-1:0]  asq_s2, bsq_s2;
	side_t            side_s3;
	logic [SQ_W-1:0]  asq_s3, bsq_s3;

	// sign-extend and take magnitude
	assign ext_re = {in_re[SAMPLE_WIDTH-1], in_re};
	assign ext_im = {in_im[SAMPLE_WIDTH-1], in_im};
	assign abs_re = ext_re[MAG_W-1] ? (~ext_re + MAG_W'(1)) : ext_re;
	assign abs_im = ext_im[MAG_W-1] ? (~ext_im + MAG_W'(1)) : ext_im;

	assign asq_full = a_s1 * a_s1;
	assign bsq_full = b_s1 * b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		// s1: magnitudes
		a_s1    <= abs_re;
		b_s1    <= abs_im;
		tag_s1  <= in_tag;
		last_s1 <= in_last;
		rneg_s1 <= in_re[SAMPLE_WIDTH-1];
		ineg_s1 <= in_im[SAMPLE_WIDTH-1];
		// s2: squares
		asq_s2  <= asq_full[SQ_W-1:0];
		bsq_s2  <= bsq_full[SQ_W-1:0];
		tag_s2  <= tag_s1;
		last_s2 <= last_s1;
		rneg_s2 <= rneg_s1;
		ineg_s2 <= ineg_s1;
		// s3: power
		side_s3.tag    <= tag_s2;
		side_s3.last   <= last_s2;
		side_s3.re_neg <= rneg_s2;
		side_s3.im_neg <= ineg_s2;
		side_s3.power  <= POW_W'(asq_s2) + POW_W'(bsq_s2);
		asq_s3 <= asq_s2;
		bsq_s3 <= bsq_s2;
	end

	assign out_valid  = valid_s3;
	assign out_side   = side_s3;
	assign out_num_re = asq_s3;
	assign out_num_im = bsq_s3;

endmodule

// ===== hw/rtl/cpm_div.sv =====
// Pipelined restoring divider: floor(num * 2^30 / power), one quotient bit per stage.
// Two lanes share the denominator. Depends on cpm_pkg.
module cpm_div import cpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  side_t            in_side,
	input  logic [SQ_W-1:0]  in_num_re,
	input  logic [SQ_W-1:0]  in_num_im,
	output logic             out_valid,
	output side_t            out_side,
	output logic [QUO_W-1:0] out_quo_re,
	output logic [QUO_W-1:0] out_quo_im
);

	logic             valid_s [DIV_STAGES];
	side_t            side_s  [DIV_STAGES];
	logic [POW_W-1:0] rem_s   [DIV_STAGES][2];
	logic [QUO_W-1:0] quo_s   [DIV_STAGES][2];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic             valid_p;
		side_t            side_p;
		logic [POW_W:0]   trial [2];
		logic             ge    [2];
		logic [QUO_W-1:0] quo_p [2];

		if (k == 0) begin : g_first
			// integer bit: num may equal power
			assign valid_p  = in_valid;
			assign side_p   = in_side;
			assign trial[0] = (POW_W+1)'(in_num_re);
			assign trial[1] = (POW_W+1)'(in_num_im);
			assign quo_p[0] = '0;
			assign quo_p[1] = '0;
		end else begin : g_next
			assign valid_p  = valid_s[k-1];
			assign side_p   = side_s[k-1];
			assign trial[0] = {rem_s[k-1][0], 1'b0};
			assign trial[1] = {rem_s[k-1][1], 1'b0};
			assign quo_p[0] = quo_s[k-1][0];
			assign quo_p[1] = quo_s[k-1][1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_p;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [POW_W:0] diff;
			assign ge[l] = trial[l] >= {1'b0, side_p.power};
			assign diff  = trial[l] - {1'b0, side_p.power};
			always_ff @(posedge clk) begin
				rem_s[k][l] <= ge[l] ? diff[POW_W-1:0] : trial[l][POW_W-1:0];
				quo_s[k][l] <= {quo_p[l][QUO_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_p;
		end
	end

	assign out_valid  = valid_s[DIV_STAGES-1];
	assign out_side   = side_s[DIV_STAGES-1];
	assign out_quo_re = quo_s[DIV_STAGES-1][0];
	assign out_quo_im = quo_s[DIV_STAGES-1][1];

endmodule

// ===== hw/rtl/cpm_root.sv =====
// Pipelined integer square root, one root bit per stage, three lanes.
// Depends on cpm_pkg.
module cpm_root import cpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  side_t             in_side,
	input  logic [POW_W-1:0]  in_rad [LANES],
	output logic              out_valid,
	output side_t             out_side,
	output logic [ROOT_W-1:0] out_root [LANES]
);

	logic              valid_s [ROOT_STAGES];
	side_t             side_s  [ROOT_STAGES];
	logic [REM_W-1:0]  rem_s   [ROOT_STAGES][LANES];
	logic [ROOT_W-1:0] root_s  [ROOT_STAGES][LANES];
	logic [POW_W-1:0]  rad_s   [ROOT_STAGES][LANES];

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
		logic valid_p;
		side_t side_p;

		if (k == 0) begin : g_first
			assign valid_p = in_valid;
			assign side_p  = in_side;
		end else begin : g_next
			assign valid_p = valid_s[k-1];
			assign side_p  = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_p;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [REM_W-1:0]  rem_p;
			logic [ROOT_W-1:0] root_p;
			logic [POW_W-1:0]  rad_p;
			logic [REM_W+1:0]  cur, trial, diff;
			logic              ge;

			if (k == 0) begin : g_first
				assign rem_p  = '0;
				assign root_p = '0;
				assign rad_p  = in_rad[l];
			end else begin : g_next
				assign rem_p  = rem_s[k-1][l];
				assign root_p = root_s[k-1][l];
				assign rad_p  = rad_s[k-1][l];
			end

			// bring down two radicand bits, try (root << 2) | 1
			assign cur   = {rem_p, rad_p[POW_W-1 -: 2]};
			assign trial = (REM_W+2)'({root_p, 2'b01});
			assign ge    = cur >= trial;
			assign diff  = cur - trial;

			always_ff @(posedge clk) begin
				rem_s[k][l]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
				root_s[k][l] <= {root_p[ROOT_W-2:0], ge};
				rad_s[k][l]  <= {rad_p[POW_W-3:0], 2'b00};
			end
		end
	end

	assign out_valid = valid_s[ROOT_STAGES-1];
	assign out_side  = side_s[ROOT_STAGES-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_root[l] = root_s[ROOT_STAGES-1][l];
	end

endmodule

// ===== hw/rtl/complex_power_magnitude_phase_unit.sv =====
// Top level: power or magnitude and unit phasor of one complex bin per cycle.
// Depends on cpm_pkg, cpm_front, cpm_div, cpm_root.
//
// channel   ports                                             handshake
// input     source_tag bin_re bin_im bin_last                 start, busy
// config    cfg_data (measure_mode)                           cfg_valid, cfg_ready
// result    tag_out level phasor_re phasor_im last_out        result_valid strobe
//
// One bin enters every cycle; busy is never raised.
// Each result, from its start beat, passes 3 front stages, 31 divider stages
// (one quotient bit each), 16 root stages and one output register.
// Reset clears the valid bits and sets power mode; no clearing pass.
// The result side has no back-pressure, so the pipeline never stalls.
module complex_power_magnitude_phase_unit import cpm_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [TAG_W-1:0]               source_tag,
	input  logic signed [SAMPLE_WIDTH-1:0] bin_re,
	input  logic signed [SAMPLE_WIDTH-1:0] bin_im,
	input  logic                           bin_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	output logic                           result_valid,
	output logic [TAG_W-1:0]               tag_out,
	output logic [LEVEL_W-1:0]             level,
	output logic signed [SAMPLE_WIDTH-1:0] phasor_re,
	output logic signed [SAMPLE_WIDTH-1:0] phasor_im,
	output logic                           last_out
);

	mode_t             mode_q;
	logic              f_valid, d_valid, r_valid;
	side_t             f_side, d_side, r_side;
	logic [SQ_W-1:0]   f_num_re, f_num_im;
	logic [QUO_W-1:0]  d_quo_re, d_quo_im;
	logic [POW_W-1:0]  rad [LANES];
	logic [ROOT_W-1:0] root [LANES];
	logic [SAMPLE_WIDTH-1:0] ph_re, ph_im;

	logic                    result_valid_q;
	logic [TAG_W-1:0]        tag_q;
	logic [LEVEL_W-1:0]      level_q;
	logic [SAMPLE_WIDTH-1:0] phasor_re_q, phasor_im_q;
	logic                    last_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_POWER;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	cpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.in_tag     (source_tag),
		.in_re      (bin_re),
		.in_im      (bin_im),
		.in_last    (bin_last),
		.out_valid  (f_valid),
		.out_side   (f_side),
		.out_num_re (f_num_re),
		.out_num_im (f_num_im)
	);

	cpm_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (f_valid),
		.in_side    (f_side),
		.in_num_re  (f_num_re),
		.in_num_im  (f_num_im),
		.out_valid  (d_valid),
		.out_side   (d_side),
		.out_quo_re (d_quo_re),
		.out_quo_im (d_quo_im)
	);

	assign rad[LANE_LEVEL] = d_side.power;
	assign rad[LANE_RE]    = POW_W'(d_quo_re);
	assign rad[LANE_IM]    = POW_W'(d_quo_im);

	cpm_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_side   (d_side),
		.in_rad    (rad),
		.out_valid (r_valid),
		.out_side  (r_side),
		.out_root  (root)
	);

	// clamp to full scale minus one, restore sign, zero bin gives zero
	function automatic logic [SAMPLE_WIDTH-1:0] shape(input logic [ROOT_W-1:0] q,
			input logic neg, input logic zero);
		logic [SAMPLE_WIDTH-1:0] mag;
		mag = q[ROOT_W-1] ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
			: {1'b0, q[SAMPLE_WIDTH-2:0]};
		if (zero) begin
			return '0;
		end
		return neg ? (~mag + SAMPLE_WIDTH'(1)) : mag;
	endfunction

	assign ph_re = shape(root[LANE_RE], r_side.re_neg, r_side.power == '0);
	assign ph_im = shape(root[LANE_IM], r_side.im_neg, r_side.power == '0);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_q       <= r_side.tag;
		last_q      <= r_side.last;
		level_q     <= (mode_q == MODE_MAGNITUDE) ? LEVEL_W'(root[LANE_LEVEL])
			: LEVEL_W'(r_side.power);
		phasor_re_q <= ph_re;
		phasor_im_q <= ph_im;
	end

	assign result_valid = result_valid_q;
	assign tag_out      = tag_q;
	assign level        = level_q;
	assign phasor_re    = phasor_re_q;
	assign phasor_im    = phasor_im_q;
	assign last_out     = last_q;

endmodule

// ===== hw/rtl/cpm_checker.sv =====
// Port-level checks for the complex power, magnitude and phasor unit, and its bind.
// Depends on cpm_pkg and complex_power_magnitude_phase_unit.
module cpm_checker import cpm_pkg::*; (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [TAG_W-1:0]               source_tag,
	input logic signed [SAMPLE_WIDTH-1:0] bin_re,
	input logic signed [SAMPLE_WIDTH-1:0] bin_im,
	input logic                           bin_last,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic                           cfg_data,
	input logic                           result_valid,
	input logic [TAG_W-1:0]               tag_out,
	input logic [LEVEL_W-1:0]             level,
	input logic signed [SAMPLE_WIDTH-1:0] phasor_re,
	input logic signed [SAMPLE_WIDTH-1:0] phasor_im,
	input logic                           last_out
);

	// every accepted beat gives a result at the fixed latency
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY result_valid)
		else $error("accepted beat produced no result");

	// no result without a correspondingly earlier accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted beat");

	// a zero level only comes from a zero bin, which has a zero phasor
	a_zero_bin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && level == '0 |-> phasor_re == '0 && phasor_im == '0)
		else $error("zero bin with nonzero phasor");

	// phasor saturates at plus or minus full scale minus one
	a_phasor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> phasor_re != {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
			&& phasor_im != {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
		else $error("phasor hit negative full scale");

endmodule

bind complex_power_magnitude_phase_unit cpm_checker u_cpm_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for complex_power_magnitude_phase_unit.
// Needs cpm_pkg and the unit's RTL; predicts power/magnitude and unit phasor per bin.
`timescale 1ns / 1ps

module testbench;
	import cpm_pkg::*;

	typedef struct {
		logic [TAG_W-1:0]               tag;
		logic [LEVEL_W-1:0]             lvl;
		logic signed [SAMPLE_WIDTH-1:0] pre;
		logic signed [SAMPLE_WIDTH-1:0] pim;
		logic                           last;
	} bin_result_t;

	// directed row: mode, bin, and optionally a hand-typed result
	typedef struct {
		mode_t                          mode;
		logic [TAG_W-1:0]               tag;
		logic signed [SAMPLE_WIDTH-1:0] re;
		logic signed [SAMPLE_WIDTH-1:0] im;
		logic                           last;
		bit                             typed;
		logic [LEVEL_W-1:0]             lvl;
		logic signed [SAMPLE_WIDTH-1:0] pre;
		logic signed [SAMPLE_WIDTH-1:0] pim;
	} bin_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [TAG_W-1:0] source_tag = '0;
	logic signed [SAMPLE_WIDTH-1:0] bin_re = '0;
	logic signed [SAMPLE_WIDTH-1:0] bin_im = '0;
	logic bin_last = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic result_valid;
	logic [TAG_W-1:0] tag_out;
	logic [LEVEL_W-1:0] level;
	logic signed [SAMPLE_WIDTH-1:0] phasor_re;
	logic signed [SAMPLE_WIDTH-1:0] phasor_im;
	logic last_out;

	mode_t       cur_mode = MODE_POWER;
	bin_result_t pending_bins[$];
	bin_result_t typed_bins[$];
	bit          typed_flags[$];
	int unsigned bins_sent = 0;
	int unsigned cfg_beats = 0;
	int unsigned bins_checked = 0;
	int unsigned errors = 0;
	int unsigned mag_bins = 0;

	complex_power_magnitude_phase_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor of the square root, bit by bit
	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// one phasor component: sqrt(a^2 * 2^30 / power), clamped, signed
	function automatic logic signed [SAMPLE_WIDTH-1:0] unit_part(longint unsigned a, bit neg,
			longint unsigned pw);
		longint unsigned q;
		if (pw == 0)
			return '0;
		q = int_sqrt(((a * a) << (2 * FRAC_BITS)) / pw);
		if (q > (64'd1 << FRAC_BITS) - 1)
			q = (64'd1 << FRAC_BITS) - 1;
		return neg ? -$signed(SAMPLE_WIDTH'(q)) : SAMPLE_WIDTH'(q);
	endfunction

	function automatic bin_result_t predict_bin(mode_t mode, logic [TAG_W-1:0] tag,
			logic signed [SAMPLE_WIDTH-1:0] re, logic signed [SAMPLE_WIDTH-1:0] im, logic last);
		bin_result_t r;
		longint signed sre, sim;
		longint unsigned a, b, pw;
		sre = re;
		sim = im;
		a = sre < 0 ? -sre : sre;
		b = sim < 0 ? -sim : sim;
		pw = a * a + b * b;
		r.tag = tag;
		r.last = last;
		r.lvl = (mode == MODE_MAGNITUDE) ? LEVEL_W'(int_sqrt(pw)) : LEVEL_W'(pw);
		r.pre = unit_part(a, sre < 0, pw);
		r.pim = unit_part(b, sim < 0, pw);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h (bin %0d)", $realtime, what, got, want,
			bins_checked);
	endtask

	// input and config beats, sampled on the rising edge
	always @(posedge clk) begin
		if (start && !busy) begin
			pending_bins.push_back(predict_bin(cur_mode, source_tag, bin_re, bin_im, bin_last));
			if (cur_mode == MODE_MAGNITUDE)
				mag_bins++;
			bins_sent++;
		end
		if (cfg_valid && cfg_ready) begin
			cur_mode = mode_t'(cfg_data);
			cfg_beats++;
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		bin_result_t w;
		if (result_valid) begin
			if (pending_bins.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat", $realtime);
			end else begin
				w = pending_bins.pop_front();
				if (typed_flags.size() != 0 && typed_flags.pop_front())
					w = typed_bins.pop_front();
				if (tag_out !== w.tag) report("tag_out", tag_out, w.tag);
				if (level !== w.lvl) report("level", level, w.lvl);
				if (phasor_re !== w.pre) report("phasor_re", phasor_re, w.pre);
				if (phasor_im !== w.pim) report("phasor_im", phasor_im, w.pim);
				if (last_out !== w.last) report("last_out", last_out, w.last);
				bins_checked++;
			end
		end
	end

	task automatic drain();
		while (pending_bins.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// stop sending, let the pipe empty, then write the mode register
	task automatic write_mode(mode_t mode);
		int unsigned n;
		start = 1'b0;
		drain();
		n = cfg_beats;
		cfg_valid = 1'b1;
		cfg_data = mode;
		do @(negedge clk); while (cfg_beats == n);
		cfg_valid = 1'b0;
	endtask

	// drive one bin at the falling edge and hold it until accepted
	task automatic send_bin(logic [TAG_W-1:0] tag, logic signed [SAMPLE_WIDTH-1:0] re,
			logic signed [SAMPLE_WIDTH-1:0] im, logic last, int unsigned gap);
		int unsigned n;
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		n = bins_sent;
		start = 1'b1;
		source_tag = tag;
		bin_re = re;
		bin_im = im;
		bin_last = last;
		do @(negedge clk); while (bins_sent == n);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			1: return '0;
			2: return SAMPLE_WIDTH'($signed($urandom_range(0, 16)) - 8);
			3: return SAMPLE_WIDTH'($signed($urandom_range(0, 1024)) - 512);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	bin_row_t dir_rows[] = '{
		'{MODE_POWER, 8'h00, 16'sd0, 16'sd0, 1'b0, 1, 32'd0, 16'sd0, 16'sd0},
		'{MODE_POWER, 8'hff, 16'sd16384, 16'sd0, 1'b1, 1, 32'h1000_0000, 16'sd32767, 16'sd0},
		'{MODE_POWER, 8'h5a, -16'sd32768, 16'sd0, 1'b0, 1, 32'h4000_0000, -16'sd32767, 16'sd0},
		'{MODE_POWER, 8'ha5, 16'sd0, -16'sd32768, 1'b1, 1, 32'h4000_0000, 16'sd0, -16'sd32767},
		'{MODE_POWER, 8'h01, -16'sd32768, -16'sd32768, 1'b0, 1, 32'h8000_0000, 16'sd0, 16'sd0},
		'{MODE_POWER, 8'h02, 16'sd32767, 16'sd32767, 1'b0, 0, '0, '0, '0},
		'{MODE_POWER, 8'h03, 16'sd1, -16'sd1, 1'b1, 0, '0, '0, '0},
		'{MODE_POWER, 8'h04, 16'sd3, 16'sd4, 1'b0, 0, '0, '0, '0},
		'{MODE_POWER, 8'h05, -16'sd1, 16'sd32767, 1'b0, 0, '0, '0, '0},
		'{MODE_POWER, 8'h06, 16'sd0, 16'sd1, 1'b1, 1, 32'd1, 16'sd0, 16'sd32767},
		'{MODE_MAGNITUDE, 8'h10, 16'sd0, 16'sd0, 1'b0, 1, 32'd0, 16'sd0, 16'sd0},
		'{MODE_MAGNITUDE, 8'h11, 16'sd3, -16'sd4, 1'b1, 1, 32'd5, '0, '0},
		'{MODE_MAGNITUDE, 8'h12, -16'sd32768, 16'sd0, 1'b0, 1, 32'd32768, -16'sd32767, 16'sd0},
		'{MODE_MAGNITUDE, 8'h13, -16'sd32768, -16'sd32768, 1'b1, 0, '0, '0, '0},
		'{MODE_MAGNITUDE, 8'h14, 16'sd32767, -16'sd32768, 1'b0, 0, '0, '0, '0},
		'{MODE_MAGNITUDE, 8'h15, 16'sd1, 16'sd1, 1'b1, 0, '0, '0, '0},
		'{MODE_POWER, 8'h20, 16'sh5555, 16'shaaaa, 1'b0, 0, '0, '0, '0},
		'{MODE_POWER, 8'h21, 16'shaaaa, 16'sh5555, 1'b1, 0, '0, '0, '0}
	};

	// the -2^15,-2^15 and 3,-4 rows mix typed and predicted fields: typed only where marked
	initial begin
		bin_result_t t;
		int unsigned gap;
		mode_t mode;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != cur_mode)
				write_mode(dir_rows[i].mode);
			t = predict_bin(dir_rows[i].mode, dir_rows[i].tag, dir_rows[i].re, dir_rows[i].im,
				dir_rows[i].last);
			if (dir_rows[i].typed) begin
				t.lvl = dir_rows[i].lvl;
				if (dir_rows[i].tag != 8'h11 && dir_rows[i].tag != 8'h01) begin
					t.pre = dir_rows[i].pre;
					t.pim = dir_rows[i].pim;
				end
			end
			typed_bins.push_back(t);
			typed_flags.push_back(1'b1);
			send_bin(dir_rows[i].tag, dir_rows[i].re, dir_rows[i].im, dir_rows[i].last, i % 3);
		end
		start = 1'b0;
		drain();
		typed_flags.delete();

		// random phases, alternating mode
		for (int ph = 0; ph < 4; ph++) begin
			mode = (ph % 2) ? MODE_MAGNITUDE : MODE_POWER;
			write_mode(mode);
			for (int k = 0; k < 258; k++) begin
				gap = ((k % 100) < 30) ? 0 : pick_gap();
				if (k == 129) begin
					start = 1'b0;
					drain();
				end
				send_bin(8'($urandom), pick_sample(), pick_sample(), 1'($urandom), gap);
			end
			start = 1'b0;
		end

		drain();
		$display("%0d bins checked (%0d in magnitude mode), %0d mode writes, zero and full-scale",
			bins_checked, mag_bins, cfg_beats);
		$display("bins included, with random gaps and a drained pause in every phase");
		if (errors == 0 && pending_bins.size() == 0)
			$display("complex_power_magnitude_phase_unit test passed");
		else
			$display("complex_power_magnitude_phase_unit test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("complex_power_magnitude_phase_unit test failed");
		$finish;
	end

endmodule
